/* rtl/cbmd_pkg.sv */
// shared types, constants and helpers of the centered block mean descriptor
`default_nettype none

package cbmd_pkg;

  localparam int MaxCells = 1024;
  localparam int CellAw   = $clog2(MaxCells);
  localparam int SumW     = 40;
  localparam int DimW     = 16;
  localparam int GridW    = 11;
  localparam int PixW     = 8;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GRID_COLUMNS  = 2'd2;
  localparam logic [1:0] REG_GRID_ROWS     = 2'd3;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_GRID = 2'd1;
  localparam logic [1:0] STAT_NOT_DONE = 2'd2;

  typedef enum logic [2:0] {
    TS_CLEAR,
    TS_RUN,
    TS_READ,
    TS_LOAD,
    TS_CALC
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIFF,
    CS_XSUM,
    CS_DIV
  } cen_state_t;

  typedef struct packed {
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [GridW-1:0] cols;
    logic [GridW-1:0] rows;
    logic [DimW-1:0]  col_q;
    logic [GridW-1:0] col_r;
    logic [DimW-1:0]  row_q;
    logic [GridW-1:0] row_r;
    logic [31:0]      pixels;
    logic [GridW-1:0] cells;
    logic             grid_ok;
  } cbmd_cfg_t;

  typedef struct packed {
    logic              pix_valid;
    logic [CellAw-1:0] pix_addr;
    logic [PixW-1:0]   pix;
    logic              clear_start;
    logic              drain_rd;
    logic [CellAw-1:0] drain_addr;
  } cbmd_mem_req_t;

  typedef struct packed {
    logic [DimW-1:0]  q;
    logic [GridW-1:0] rem;
  } edge_t;

  // next edge from quotient and remainder of k*s/g, adding s/g and s%g
  function automatic edge_t edge_step(input logic [DimW-1:0] q, input logic [GridW-1:0] rem,
                                      input logic [DimW-1:0] qs, input logic [GridW-1:0] rs,
                                      input logic [GridW-1:0] g);
    logic [GridW:0] s;
    edge_t e;
    s = {1'b0, rem} + {1'b0, rs};
    if (s >= {1'b0, g}) begin
      e.q   = q + qs + 16'd1;
      e.rem = GridW'(s - {1'b0, g});
    end else begin
      e.q   = q + qs;
      e.rem = s[GridW-1:0];
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/cbmd_cfg.sv */
// configuration registers, grid check and edge step divider
`default_nettype none

module cbmd_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [3:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output cbmd_pkg::cbmd_cfg_t      cfg_o,
  output logic                     restart_o
);
  import cbmd_pkg::*;

  logic [DimW-1:0]  width_r, height_r;
  logic [GridW-1:0] cols_r, rows_r;
  logic             wr_en;
  logic [1:0]       idx;

  logic             div_start_r;
  logic [4:0]       div_cnt_r;
  logic [DimW-1:0]  dvd_w_r, dvd_h_r, q_w_r, q_h_r;
  logic [GridW-1:0] rem_w_r, rem_h_r;
  logic [GridW:0]   rc_w, rc_h;
  logic             ge_w, ge_h;

  logic [31:0]      pixels_r;
  logic [GridW-1:0] cells_r;
  logic             ok_r;
  logic [21:0]      cell_prod;

  assign idx       = cfg_paddr[3:2];
  assign wr_en     = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart_o = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd64;
      height_r <= 16'd64;
      cols_r   <= 11'd8;
      rows_r   <= 11'd8;
    end else if (wr_en) begin
      case (idx)
        REG_SOURCE_WIDTH:  width_r  <= cfg_pwdata[DimW-1:0];
        REG_SOURCE_HEIGHT: height_r <= cfg_pwdata[DimW-1:0];
        REG_GRID_COLUMNS:  cols_r   <= cfg_pwdata[GridW-1:0];
        REG_GRID_ROWS:     rows_r   <= cfg_pwdata[GridW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_WIDTH:  cfg_prdata = {16'd0, width_r};
      REG_SOURCE_HEIGHT: cfg_prdata = {16'd0, height_r};
      REG_GRID_COLUMNS:  cfg_prdata = {21'd0, cols_r};
      REG_GRID_ROWS:     cfg_prdata = {21'd0, rows_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // restoring divide of width by columns and height by rows, one bit a cycle
  assign rc_w = {rem_w_r, dvd_w_r[DimW-1]};
  assign rc_h = {rem_h_r, dvd_h_r[DimW-1]};
  assign ge_w = rc_w >= {1'b0, cols_r};
  assign ge_h = rc_h >= {1'b0, rows_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_start_r <= 1'b1;
      div_cnt_r   <= 5'd0;
    end else begin
      div_start_r <= wr_en;
      if (div_start_r) begin
        div_cnt_r <= 5'd16;
      end else if (div_cnt_r != 5'd0) begin
        div_cnt_r <= div_cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start_r) begin
      dvd_w_r <= width_r;
      dvd_h_r <= height_r;
      rem_w_r <= '0;
      rem_h_r <= '0;
      q_w_r   <= '0;
      q_h_r   <= '0;
    end else if (div_cnt_r != 5'd0) begin
      dvd_w_r <= {dvd_w_r[DimW-2:0], 1'b0};
      dvd_h_r <= {dvd_h_r[DimW-2:0], 1'b0};
      rem_w_r <= ge_w ? GridW'(rc_w - {1'b0, cols_r}) : rc_w[GridW-1:0];
      rem_h_r <= ge_h ? GridW'(rc_h - {1'b0, rows_r}) : rc_h[GridW-1:0];
      q_w_r   <= {q_w_r[DimW-2:0], ge_w};
      q_h_r   <= {q_h_r[DimW-2:0], ge_h};
    end
  end

  assign cell_prod = cols_r * rows_r;

  always_ff @(posedge clk) begin
    pixels_r <= width_r * height_r;
    cells_r  <= cell_prod[GridW-1:0];
    ok_r     <= (width_r != 16'd0) && (height_r != 16'd0) && (cols_r != 11'd0) &&
                (rows_r != 11'd0) && ({5'd0, cols_r} <= width_r) &&
                ({5'd0, rows_r} <= height_r) && (cell_prod <= 22'(MaxCells));
  end

  always_comb begin
    cfg_o.width   = width_r;
    cfg_o.height  = height_r;
    cfg_o.cols    = cols_r;
    cfg_o.rows    = rows_r;
    cfg_o.col_q   = q_w_r;
    cfg_o.col_r   = rem_w_r;
    cfg_o.row_q   = q_h_r;
    cfg_o.row_r   = rem_h_r;
    cfg_o.pixels  = pixels_r;
    cfg_o.cells   = cells_r;
    cfg_o.grid_ok = ok_r;
  end

endmodule

`default_nettype wire

/* rtl/cbmd_cell_mem.sv */
// cell sum memory with pixel read-modify-write, clearing pass and drain read
`default_nettype none

module cbmd_cell_mem (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbmd_pkg::cbmd_mem_req_t req,
  output logic                      clear_busy,
  output logic [cbmd_pkg::SumW-1:0] drain_sum
);
  import cbmd_pkg::*;

  logic [SumW-1:0]   mem [MaxCells];
  logic [SumW-1:0]   rdata_r;

  logic              clr_busy_r;
  logic [CellAw-1:0] clr_cnt_r;

  logic              s1_valid_r;
  logic [CellAw-1:0] s1_addr_r;
  logic [PixW-1:0]   s1_px_r;
  logic              hit_r;
  logic [SumW-1:0]   fwd_r;
  logic [SumW-1:0]   s1_sum;

  logic              drain_wr_r;
  logic [CellAw-1:0] drain_wa_r;

  logic              re, we;
  logic [CellAw-1:0] ra, wa;
  logic [SumW-1:0]   wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      drain_wr_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (req.clear_start) begin
        clr_busy_r <= 1'b1;
        clr_cnt_r  <= '0;
      end else if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CellAw'(MaxCells - 1)) clr_busy_r <= 1'b0;
      end
      s1_valid_r <= req.pix_valid;
      drain_wr_r <= req.drain_rd;
      // previous pixel writes the same cell at the edge this read is taken
      hit_r      <= req.pix_valid && s1_valid_r && (s1_addr_r == req.pix_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.pix_valid) begin
      s1_addr_r <= req.pix_addr;
      s1_px_r   <= req.pix;
    end
    if (req.drain_rd) drain_wa_r <= req.drain_addr;
    fwd_r <= s1_sum;
  end

  assign s1_sum = (hit_r ? fwd_r : rdata_r) + {{(SumW-PixW){1'b0}}, s1_px_r};

  always_comb begin
    re = req.pix_valid || req.drain_rd;
    ra = req.drain_rd ? req.drain_addr : req.pix_addr;
    we = 1'b1;
    wa = clr_cnt_r;
    wd = '0;
    if (clr_busy_r) begin
      wa = clr_cnt_r;
    end else if (s1_valid_r) begin
      wa = s1_addr_r;
      wd = s1_sum;
    end else if (drain_wr_r) begin
      // drained cell goes back to zero for the next image
      wa = drain_wa_r;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_r <= mem[ra];
  end

  assign clear_busy = clr_busy_r;
  assign drain_sum  = rdata_r;

endmodule

`default_nettype wire

/* rtl/cbmd_centered.sv */
// centered mean unit: shift-add products, then restoring divide with rounding
`default_nettype none

module cbmd_centered (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [cbmd_pkg::SumW-1:0] cell_sum,
  input  wire logic [cbmd_pkg::SumW-1:0] image_sum,
  input  wire logic [31:0]          cell_pixels,
  input  wire logic [31:0]          image_pixels,
  output logic                      done,
  output logic [7:0]                value
);
  import cbmd_pkg::*;

  cen_state_t  state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [71:0] a1_r, a2_r, ms_r, mt_r, mag_r;
  logic [63:0] a3_r, mn_r;
  logic [31:0] bn_r, bm_r;
  logic        neg_r, sat_r, done_r;
  logic [73:0] rem_r, dd_r;
  logic [6:0]  q_r;
  logic        ge;
  logic [7:0]  mag8;
  logic        mul_en, diff_en, xsum_en, div_en;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (start) state_nxt = CS_MUL;
      CS_MUL:  if (cnt_r == 5'd31) state_nxt = CS_DIFF;
      CS_DIFF: state_nxt = CS_XSUM;
      CS_XSUM: state_nxt = CS_DIV;
      CS_DIV:  if (cnt_r == 5'd7) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    mul_en  = 1'b0;
    diff_en = 1'b0;
    xsum_en = 1'b0;
    div_en  = 1'b0;
    case (state_r)
      CS_MUL:  mul_en  = 1'b1;
      CS_DIFF: diff_en = 1'b1;
      CS_XSUM: xsum_en = 1'b1;
      CS_DIV:  div_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= div_en && (cnt_r == 5'd7);
    end
  end

  assign ge = rem_r >= dd_r;

  always_ff @(posedge clk) begin
    if (state_r == CS_IDLE && start) begin
      a1_r  <= '0;
      a2_r  <= '0;
      a3_r  <= '0;
      ms_r  <= 72'(cell_sum);
      mt_r  <= 72'(image_sum);
      mn_r  <= 64'(cell_pixels);
      bn_r  <= image_pixels;
      bm_r  <= cell_pixels;
      cnt_r <= '0;
    end else if (mul_en) begin
      // cell_sum*N, image_sum*n and n*N, one multiplier bit a cycle
      if (bn_r[0]) begin
        a1_r <= a1_r + ms_r;
        a3_r <= a3_r + mn_r;
      end
      if (bm_r[0]) a2_r <= a2_r + mt_r;
      ms_r  <= {ms_r[70:0], 1'b0};
      mt_r  <= {mt_r[70:0], 1'b0};
      mn_r  <= {mn_r[62:0], 1'b0};
      bn_r  <= {1'b0, bn_r[31:1]};
      bm_r  <= {1'b0, bm_r[31:1]};
      cnt_r <= cnt_r + 5'd1;
    end else if (diff_en) begin
      neg_r <= a2_r > a1_r;
      mag_r <= (a2_r > a1_r) ? (a2_r - a1_r) : (a1_r - a2_r);
    end else if (xsum_en) begin
      // 2|num| + den over 2*den gives the magnitude rounded half up
      rem_r <= {1'b0, mag_r, 1'b0} + {10'd0, a3_r};
      dd_r  <= {2'd0, a3_r, 8'd0};
      q_r   <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
    end else if (div_en) begin
      if (cnt_r == 5'd0) begin
        sat_r <= ge;
      end else begin
        if (ge) rem_r <= rem_r - dd_r;
        q_r <= {q_r[5:0], ge};
      end
      dd_r  <= {1'b0, dd_r[73:1]};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign mag8  = sat_r ? 8'd127 : {1'b0, q_r};
  assign value = neg_r ? (8'd0 - mag8) : mag8;
  assign done  = done_r;

endmodule

`default_nettype wire

/* rtl/centered_block_mean_descriptor_core.sv */
// top level: pixel raster tracking, drain sequencing and output register
// pixels are taken one per cycle in the run state while no unread result waits on the output
// an error fetch shows its result in the cycle after acceptance
// a drain fetch shows its value after the cell read, the load, the shift-add products,
// the difference and offset, the divide and done; one drain fetch in flight at a time
// reset and every register write run a clearing pass over all 1024 cells with the input held off
`default_nettype none

module centered_block_mean_descriptor_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel
  input  wire logic [0:0]  in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] value
  output logic             out_tlast,
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cbmd_pkg::*;

  cbmd_cfg_t     cfg;
  cbmd_mem_req_t mreq;
  logic          restart;
  logic          clear_busy;
  logic [SumW-1:0] drain_sum;
  logic          cen_start, cen_done;
  logic [7:0]    cen_value;

  top_state_t        state_r, state_nxt;
  logic [DimW-1:0]   col_pos_r, col_pos_nxt, row_pos_r, row_pos_nxt;
  logic [DimW-1:0]   col_edge_r, col_edge_nxt, row_edge_r, row_edge_nxt;
  logic [GridW-1:0]  col_rem_r, col_rem_nxt, row_rem_r, row_rem_nxt;
  logic [CellAw-1:0] row_base_r, row_base_nxt, cell_addr_r, cell_addr_nxt;
  logic [SumW-1:0]   image_sum_r, image_sum_nxt;
  logic              done_r, done_nxt;
  logic [CellAw-1:0] d_addr_r, d_addr_nxt, d_gx_r, d_gx_nxt;
  logic [GridW-1:0]  d_xrem_r, d_xrem_nxt, d_yrem_r, d_yrem_nxt;
  logic [31:0]       n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0]        out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              in_acc, push, fetch, drain_rd;
  logic              drain_end, restart_pos;
  logic [DimW-1:0]   wc, hc;
  logic [GridW:0]    xs, ys;

  cbmd_cfg u_cfg (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  cbmd_cell_mem u_mem (
    .clk, .rst_n,
    .req        (mreq),
    .clear_busy (clear_busy),
    .drain_sum  (drain_sum)
  );

  cbmd_centered u_cen (
    .clk, .rst_n,
    .start        (cen_start),
    .cell_sum     (drain_sum),
    .image_sum    (image_sum_r),
    .cell_pixels  (n_r),
    .image_pixels (cfg.pixels),
    .done         (cen_done),
    .value        (cen_value)
  );

  assign cfg_pready = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign push       = in_acc && (in_tuser[0] == CMD_PUSH) && cfg.grid_ok && !done_r;
  assign fetch      = in_acc && (in_tuser[0] == CMD_FETCH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_CLEAR: if (!clear_busy) state_nxt = TS_RUN;
      TS_RUN:   if (fetch && cfg.grid_ok && done_r) state_nxt = TS_READ;
      TS_READ:  state_nxt = TS_LOAD;
      TS_LOAD:  state_nxt = TS_CALC;
      TS_CALC:  if (cen_done) state_nxt = TS_RUN;
      default:  state_nxt = TS_CLEAR;
    endcase
    if (restart) state_nxt = TS_CLEAR;
  end

  // outputs of the state machine
  always_comb begin
    in_tready = 1'b0;
    drain_rd  = 1'b0;
    cen_start = 1'b0;
    case (state_r)
      TS_RUN:  in_tready = !out_valid_r || out_tready;
      TS_READ: drain_rd  = 1'b1;
      TS_LOAD: cen_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    mreq.pix_valid   = push;
    mreq.pix_addr    = cell_addr_r;
    mreq.pix         = in_tdata;
    mreq.clear_start = restart;
    mreq.drain_rd    = drain_rd;
    mreq.drain_addr  = d_addr_r;
  end

  // size of the cell being drained from the edge remainders
  assign xs = {1'b0, d_xrem_r} + {1'b0, cfg.col_r};
  assign ys = {1'b0, d_yrem_r} + {1'b0, cfg.row_r};
  assign wc = cfg.col_q + 16'(xs >= {1'b0, cfg.cols});
  assign hc = cfg.row_q + 16'(ys >= {1'b0, cfg.rows});

  assign drain_end   = (state_r == TS_CALC) && cen_done &&
                       ({1'b0, d_addr_r} + 11'd1 >= cfg.cells);
  assign restart_pos = (state_r == TS_CLEAR) || drain_end;

  always_comb begin
    logic [DimW:0]     col_p1, row_p1;
    logic [CellAw-1:0] base_next;
    edge_t             ce, re, dx, dy;
    col_pos_nxt    = col_pos_r;
    row_pos_nxt    = row_pos_r;
    col_edge_nxt   = col_edge_r;
    col_rem_nxt    = col_rem_r;
    row_edge_nxt   = row_edge_r;
    row_rem_nxt    = row_rem_r;
    row_base_nxt   = row_base_r;
    cell_addr_nxt  = cell_addr_r;
    image_sum_nxt  = image_sum_r;
    done_nxt       = done_r;
    d_addr_nxt     = d_addr_r;
    d_gx_nxt       = d_gx_r;
    d_xrem_nxt     = d_xrem_r;
    d_yrem_nxt     = d_yrem_r;
    n_nxt          = n_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    col_p1    = {1'b0, col_pos_r} + 17'd1;
    row_p1    = {1'b0, row_pos_r} + 17'd1;
    base_next = row_base_r + cfg.cols[CellAw-1:0];
    ce = edge_step(col_edge_r, col_rem_r, cfg.col_q, cfg.col_r, cfg.cols);
    re = edge_step(row_edge_r, row_rem_r, cfg.row_q, cfg.row_r, cfg.rows);
    dx = edge_step(16'd0, d_xrem_r, cfg.col_q, cfg.col_r, cfg.cols);
    dy = edge_step(16'd0, d_yrem_r, cfg.row_q, cfg.row_r, cfg.rows);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (push) begin
      image_sum_nxt = image_sum_r + {{(SumW-PixW){1'b0}}, in_tdata};
      if (col_p1 >= {1'b0, cfg.width}) begin
        col_pos_nxt   = '0;
        col_edge_nxt  = cfg.col_q;
        col_rem_nxt   = cfg.col_r;
        row_pos_nxt   = row_p1[DimW-1:0];
        cell_addr_nxt = row_base_r;
        if (row_p1 >= {1'b0, cfg.height}) begin
          done_nxt = 1'b1;
        end else if (row_p1 == {1'b0, row_edge_r}) begin
          row_base_nxt  = base_next;
          cell_addr_nxt = base_next;
          row_edge_nxt  = re.q;
          row_rem_nxt   = re.rem;
        end
      end else begin
        col_pos_nxt = col_p1[DimW-1:0];
        if (col_p1 == {1'b0, col_edge_r}) begin
          cell_addr_nxt = cell_addr_r + 1'b1;
          col_edge_nxt  = ce.q;
          col_rem_nxt   = ce.rem;
        end
      end
    end

    if (fetch && !cfg.grid_ok) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = 8'd0;
      out_last_nxt   = 1'b0;
      out_status_nxt = STAT_BAD_GRID;
    end else if (fetch && !done_r) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = 8'd0;
      out_last_nxt   = 1'b0;
      out_status_nxt = STAT_NOT_DONE;
    end

    if (state_r == TS_READ) n_nxt = wc * hc;

    if (state_r == TS_CALC && cen_done) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = cen_value;
      out_last_nxt   = drain_end;
      out_status_nxt = STAT_OK;
      d_addr_nxt     = d_addr_r + 1'b1;
      if ({1'b0, d_gx_r} + 11'd1 == cfg.cols) begin
        d_gx_nxt   = '0;
        d_xrem_nxt = '0;
        d_yrem_nxt = dy.rem;
      end else begin
        d_gx_nxt   = d_gx_r + 1'b1;
        d_xrem_nxt = dx.rem;
      end
    end

    if (restart_pos) begin
      col_pos_nxt   = '0;
      row_pos_nxt   = '0;
      col_edge_nxt  = cfg.col_q;
      col_rem_nxt   = cfg.col_r;
      row_edge_nxt  = cfg.row_q;
      row_rem_nxt   = cfg.row_r;
      row_base_nxt  = '0;
      cell_addr_nxt = '0;
      image_sum_nxt = '0;
      done_nxt      = 1'b0;
      d_addr_nxt    = '0;
      d_gx_nxt      = '0;
      d_xrem_nxt    = '0;
      d_yrem_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_CLEAR;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_pos_r    <= col_pos_nxt;
    row_pos_r    <= row_pos_nxt;
    col_edge_r   <= col_edge_nxt;
    col_rem_r    <= col_rem_nxt;
    row_edge_r   <= row_edge_nxt;
    row_rem_r    <= row_rem_nxt;
    row_base_r   <= row_base_nxt;
    cell_addr_r  <= cell_addr_nxt;
    image_sum_r  <= image_sum_nxt;
    d_addr_r     <= d_addr_nxt;
    d_gx_r       <= d_gx_nxt;
    d_xrem_r     <= d_xrem_nxt;
    d_yrem_r     <= d_yrem_nxt;
    n_r          <= n_nxt;
    out_last_r   <= out_last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

/* rtl/cbmd_checker.sv */
// port-level checks on the result channel, bound to the top level
`default_nettype none

module cbmd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [1:0] out_tuser
);
  import cbmd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata == 8'd0) && !out_tlast)
    else $error("error result carries value or last");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 8'h80)
    else $error("value outside clamp range");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_OK) || (out_tuser == STAT_BAD_GRID) ||
                   (out_tuser == STAT_NOT_DONE))
    else $error("unknown status code");

endmodule

bind centered_block_mean_descriptor_core cbmd_checker u_cbmd_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// testbench for the centered block mean descriptor core: stream driver, checker, apb writes
`timescale 1ns / 100ps

module tb_top;
  import cbmd_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int DrainWait = 80;
  localparam int ItemGoal  = 1800;

  typedef struct {
    logic            cmd;
    logic [PixW-1:0] pix;
  } pix_cmd_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic [1:0] status;
  } cell_value_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] pixel
  logic [0:0]  in_tuser = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] value
  logic        out_tlast;
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  centered_block_mean_descriptor_core i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // descriptor predictor state
  longint unsigned cell_acc [MaxCells];
  longint unsigned image_acc;
  int unsigned img_w, img_h, grid_c, grid_r;
  int unsigned col_pos, row_pos, cell_col, cell_row, col_edge, row_edge, drain_pos;
  bit          image_full;

  pix_cmd_t    pending_pixels[$];
  cell_value_t expected_cells[$];
  int          error_count = 0;
  int          queued_items = 0;

  function automatic bit grid_valid();
    if (img_w == 0 || img_h == 0 || grid_c == 0 || grid_r == 0) return 0;
    if (grid_c > img_w || grid_r > img_h) return 0;
    return longint'(grid_c) * grid_r <= MaxCells;
  endfunction

  function automatic int unsigned edge_pos(int unsigned k, int unsigned s, int unsigned g);
    return int'((longint'(k) * s) / g);
  endfunction

  task automatic restart_image();
    foreach (cell_acc[i]) cell_acc[i] = 0;
    image_acc = 0;
    col_pos = 0; row_pos = 0; cell_col = 0; cell_row = 0; drain_pos = 0;
    image_full = 0;
    col_edge = grid_valid() ? edge_pos(1, img_w, grid_c) : 0;
    row_edge = grid_valid() ? edge_pos(1, img_h, grid_r) : 0;
  endtask

  // round(s/n - t/nn) half away from zero, clamped to +-127
  function automatic int centered_mean(longint unsigned s, longint unsigned n,
                                       longint unsigned t, longint unsigned nn);
    int d;
    longint unsigned a, b, den, f;
    bit up, up_s, dn, dn_s;
    int r;
    d = int'(s / n) - int'(t / nn);
    a = (s % n) * nn;
    b = (t % nn) * n;
    den = n * nn;
    up = 0; up_s = 0; dn = 0; dn_s = 0;
    if (a >= b) begin
      f = a - b;
      up = f >= den - f;
      up_s = f > den - f;
    end
    if (b >= a) begin
      f = b - a;
      dn = f >= den - f;
      dn_s = f > den - f;
    end
    if (d > 0) r = d + up - dn_s;
    else if (d < 0) r = d - dn + up_s;
    else r = up ? 1 : (dn ? -1 : 0);
    if (r > 127) r = 127;
    if (r < -127) r = -127;
    return r;
  endfunction

  task automatic predict_item(pix_cmd_t it);
    cell_value_t res;
    int unsigned cells, idx, gx, gy;
    longint unsigned n;
    if (it.cmd == CMD_PUSH) begin
      if (!grid_valid() || image_full) return;
      idx = cell_row * grid_c + cell_col;
      if (idx < MaxCells) cell_acc[idx] += it.pix;
      image_acc += it.pix;
      col_pos++;
      if (col_pos >= img_w) begin
        col_pos = 0;
        cell_col = 0;
        col_edge = edge_pos(1, img_w, grid_c);
        row_pos++;
        if (row_pos >= img_h) image_full = 1;
        else if (row_pos == row_edge) begin
          cell_row++;
          row_edge = edge_pos(cell_row + 1, img_h, grid_r);
        end
      end else if (col_pos == col_edge) begin
        cell_col++;
        col_edge = edge_pos(cell_col + 1, img_w, grid_c);
      end
      return;
    end
    res.value = '0;
    res.last = 1'b0;
    if (!grid_valid()) res.status = STAT_BAD_GRID;
    else if (!image_full) res.status = STAT_NOT_DONE;
    else begin
      cells = grid_c * grid_r;
      idx = (drain_pos >= cells) ? cells - 1 : drain_pos;
      gy = idx / grid_c;
      gx = idx % grid_c;
      n = longint'(edge_pos(gx + 1, img_w, grid_c) - edge_pos(gx, img_w, grid_c))
        * longint'(edge_pos(gy + 1, img_h, grid_r) - edge_pos(gy, img_h, grid_r));
      res.value = 8'(centered_mean(cell_acc[idx], n, image_acc, longint'(img_w) * img_h));
      res.status = STAT_OK;
      if (idx + 1 >= cells) begin
        res.last = 1'b1;
        restart_image();
      end else drain_pos = idx + 1;
    end
    expected_cells.insert(expected_cells.size(), res);
  endtask

  task automatic report(string field, int got, int exp);
    $display("mismatch on %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
    error_count++;
  endtask

  // input driver: one transaction at a time from the pending queue
  int  send_gap = 0;
  bit  send_idle = 1;
  int  sent = 0;
  always @(posedge clk) begin
    pix_cmd_t it;
    logic v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      v = in_tvalid;
      if (in_tvalid && in_tready) begin
        it.cmd = in_tuser[0];
        it.pix = in_tdata;
        predict_item(it);
        v = 1'b0;
        sent++;
        if (sent % 300 == 0) send_idle = $urandom_range(0, 2) != 0;
        send_gap = send_idle ? $urandom_range(0, 9) : 0;
      end
      if (!v) begin
        if (send_gap > 0) send_gap--;
        else if (pending_pixels.size() > 0) begin
          it = pending_pixels.pop_front();
          in_tuser <= it.cmd;
          in_tdata <= it.pix;
          v = 1'b1;
        end
      end
      in_tvalid <= v;
    end
  end

  // receiver: random stalls plus one long hold while the sender still has work queued
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  int  recvd = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        recvd++;
        recv_gap = ((recvd / 150) % 3 == 2) ? 0 : $urandom_range(0, 9);
      end
      if (!hold_done && recvd >= 30 && pending_pixels.size() > 40) begin
        hold_done = 1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_value_t exp_cell;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        exp_cell = expected_cells.pop_front();
        if (out_tdata !== exp_cell.value)
          report("value", $signed(out_tdata), $signed(exp_cell.value));
        if (out_tlast !== exp_cell.last) report("last", out_tlast, exp_cell.last);
        if (out_tuser !== exp_cell.status) report("status", out_tuser, exp_cell.status);
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic add_item(logic cmd, logic [7:0] pix);
    pix_cmd_t it;
    it.cmd = cmd;
    it.pix = pix;
    pending_pixels.insert(pending_pixels.size(), it);
    queued_items++;
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_tvalid || expected_cells.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, int unsigned val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (reg_idx)
      REG_SOURCE_WIDTH:  img_w = val & 32'hFFFF;
      REG_SOURCE_HEIGHT: img_h = val & 32'hFFFF;
      REG_GRID_COLUMNS:  grid_c = val & 32'h7FF;
      default:           grid_r = val & 32'h7FF;
    endcase
    restart_image();
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned c, int unsigned r);
    wait_idle();
    cfg_write(REG_SOURCE_WIDTH, w);
    cfg_write(REG_SOURCE_HEIGHT, h);
    cfg_write(REG_GRID_COLUMNS, c);
    cfg_write(REG_GRID_ROWS, r);
  endtask

  function automatic logic [7:0] draw_pixel(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: return 8'($urandom_range(100, 140));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned w, h, c, r;
    int mode;
    img_w = 64; img_h = 64; grid_c = 8; grid_r = 8;
    restart_image();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // early fetch on the reset grid, then a few pixels of an unfinished image
    add_item(CMD_FETCH, 8'h00);
    add_item(CMD_PUSH, 8'hFF);
    add_item(CMD_PUSH, 8'h00);
    add_item(CMD_FETCH, 8'h00);
    // one pixel image, then extra pixel and next-image early fetch
    set_grid(1, 1, 1, 1);
    add_item(CMD_PUSH, 8'hFF);
    add_item(CMD_PUSH, 8'h55);
    add_item(CMD_FETCH, 8'h00);
    add_item(CMD_FETCH, 8'h00);
    // clamp to -127 and +127 with a half tie
    set_grid(2, 1, 2, 1);
    add_item(CMD_PUSH, 8'h00);
    add_item(CMD_PUSH, 8'hFF);
    add_item(CMD_PUSH, 8'hAA);
    add_item(CMD_FETCH, 8'h00);
    add_item(CMD_FETCH, 8'h00);
    // columns beyond width: invalid grid, pushes ignored
    set_grid(1, 1, 2, 1);
    add_item(CMD_PUSH, 8'h12);
    add_item(CMD_FETCH, 8'h00);
    // widest source registers with too many cells, then exactly 1024 cells, then zero width
    set_grid(65535, 65535, 1024, 1024);
    add_item(CMD_FETCH, 8'h00);
    set_grid(65535, 65535, 1024, 1);
    add_item(CMD_PUSH, 8'h7F);
    add_item(CMD_FETCH, 8'h00);
    set_grid(0, 3, 1, 1);
    add_item(CMD_FETCH, 8'h00);

    while (queued_items < ItemGoal) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 14);
      c = $urandom_range(1, w);
      r = $urandom_range(1, h);
      case ($urandom_range(0, 11))
        0: c = w + 1;
        1: r = 0;
        2: begin w = 65535; h = 1 + $urandom_range(0, 65534); c = 33; r = 33; end
        default: ;
      endcase
      set_grid(w, h, c, r);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < w * h && i < 400 && queued_items < ItemGoal; i++) begin
        if ($urandom_range(0, 40) == 0) add_item(CMD_FETCH, 8'($urandom));
        add_item(CMD_PUSH, draw_pixel(mode));
      end
      if ($urandom_range(0, 3) == 0) add_item(CMD_PUSH, 8'($urandom));
      for (int i = 0; i < c * r && i < 1024 && queued_items < ItemGoal; i++)
        add_item(CMD_FETCH, 8'($urandom));
      if ($urandom_range(0, 3) == 0) add_item(CMD_FETCH, 8'h00);
    end

    wait_idle();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
